// ----- design/aesrt_pkg.sv -----
package aesrt_pkg;

	typedef enum logic [2:0] {
		ACT_ADDKEY   = 3'd0,
		ACT_SUB      = 3'd1,
		ACT_INVSUB   = 3'd2,
		ACT_SHIFT    = 3'd3,
		ACT_INVSHIFT = 3'd4,
		ACT_MIX      = 3'd5,
		ACT_INVMIX   = 3'd6,
		ACT_PASS     = 3'd7
	} action_t;

	typedef logic [7:0] byte_t;
	typedef byte_t [15:0] block_t;

	localparam byte_t GF_POLY   = 8'h1B;
	localparam byte_t AFF_CONST = 8'h63;
	localparam byte_t INV_CONST = 8'h05;

	function automatic byte_t xtime(input byte_t v);
		xtime = {v[6:0], 1'b0} ^ (v[7] ? GF_POLY : 8'h00);
	endfunction

	function automatic byte_t gmul(input byte_t a, input byte_t b);
		byte_t acc;
		byte_t x;
		acc = 8'h00;
		x = a;
		for (int i = 0; i < 8; i++) begin
			if (b[i])
				acc = acc ^ x;
			x = xtime(x);
		end
		gmul = acc;
	endfunction

	function automatic byte_t ginv(input byte_t x);
		byte_t acc;
		byte_t base;
		logic [7:0] e;
		acc = 8'h01;
		base = x;
		e = 8'd254;
		for (int i = 0; i < 8; i++) begin
			if (e[i])
				acc = gmul(acc, base);
			base = gmul(base, base);
		end
		ginv = acc;
	endfunction

	function automatic byte_t rotl(input byte_t v, input int n);
		rotl = byte_t'((v << n) | (v >> (8 - n)));
	endfunction

	function automatic byte_t sbox_calc(input byte_t x);
		byte_t v;
		v = ginv(x);
		sbox_calc = v ^ rotl(v, 1) ^ rotl(v, 2) ^ rotl(v, 3) ^ rotl(v, 4) ^ AFF_CONST;
	endfunction

	function automatic byte_t inv_sbox_calc(input byte_t x);
		inv_sbox_calc = ginv(rotl(x, 1) ^ rotl(x, 3) ^ rotl(x, 6) ^ INV_CONST);
	endfunction

	function automatic block_t unpack(input logic [63:0] hi, input logic [63:0] lo);
		block_t b;
		for (int i = 0; i < 8; i++) begin
			b[i]     = hi[63 - 8 * i -: 8];
			b[8 + i] = lo[63 - 8 * i -: 8];
		end
		unpack = b;
	endfunction

endpackage

// ----- design/aesrt_sbox.sv -----
module aesrt_sbox
	import aesrt_pkg::*;
(
	input  byte_t din,
	output byte_t fwd,
	output byte_t inv
);

	byte_t fwd_tab [256];
	byte_t inv_tab [256];

	always_comb begin
		for (int i = 0; i < 256; i++) begin
			fwd_tab[i] = sbox_calc(byte_t'(i));
			inv_tab[i] = inv_sbox_calc(byte_t'(i));
		end
	end

	assign fwd = fwd_tab[din];
	assign inv = inv_tab[din];

endmodule

// ----- design/aesrt_mix.sv -----
module aesrt_mix
	import aesrt_pkg::*;
(
	input  block_t din,
	output block_t fwd,
	output block_t inv
);

	always_comb begin
		byte_t a0, a1, a2, a3;
		for (int c = 0; c < 4; c++) begin
			a0 = din[4 * c];
			a1 = din[4 * c + 1];
			a2 = din[4 * c + 2];
			a3 = din[4 * c + 3];
			fwd[4 * c]     = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
			fwd[4 * c + 1] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
			fwd[4 * c + 2] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
			fwd[4 * c + 3] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
			inv[4 * c]     = gmul(a0, 8'd14) ^ gmul(a1, 8'd11) ^ gmul(a2, 8'd13) ^ gmul(a3, 8'd9);
			inv[4 * c + 1] = gmul(a0, 8'd9) ^ gmul(a1, 8'd14) ^ gmul(a2, 8'd11) ^ gmul(a3, 8'd13);
			inv[4 * c + 2] = gmul(a0, 8'd13) ^ gmul(a1, 8'd9) ^ gmul(a2, 8'd14) ^ gmul(a3, 8'd11);
			inv[4 * c + 3] = gmul(a0, 8'd11) ^ gmul(a1, 8'd13) ^ gmul(a2, 8'd9) ^ gmul(a3, 8'd14);
		end
	end

endmodule

// ----- design/aes_round_transform_unit_core.sv -----
// One AES-128 round transformation per word: AddRoundKey, (Inv)SubBytes,
// (Inv)ShiftRows or (Inv)MixColumns on a column-major 128-bit state, byte 0
// in state_hi[63:56]. Selector 7 passes the state through. Input is
// registered, one transform runs between the input and result registers,
// and the result is driven onto the outputs from the result register; a
// new word is taken every cycle while the output is not stalled (full rate,
// one word per clock), and a stalled output holds off the input only once
// both registers are full.
module aes_round_transform_unit_core
	import aesrt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  action,
	input  logic [63:0] state_hi,
	input  logic [63:0] state_lo,
	input  logic [63:0] key_hi,
	input  logic [63:0] key_lo,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] result_hi,
	output logic [63:0] result_lo
);

	logic    vld_s1;
	action_t act_s1;
	block_t  st_s1;
	block_t  key_s1;
	logic    vld_s2;
	block_t  res_s2;
	logic    adv_s1;
	logic    adv_s2;
	block_t  sub_f;
	block_t  sub_i;
	block_t  mix_f;
	block_t  mix_i;
	block_t  nxt;

	assign adv_s2   = !vld_s2 || !out_stall;
	assign adv_s1   = !vld_s1 || adv_s2;
	assign in_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (adv_s1)
				vld_s1 <= in_valid;
			if (adv_s2)
				vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			act_s1 <= action_t'(action);
			st_s1  <= unpack(state_hi, state_lo);
			key_s1 <= unpack(key_hi, key_lo);
		end
		if (adv_s2 && vld_s1)
			res_s2 <= nxt;
	end

	genvar g;
	generate
		for (g = 0; g < 16; g++) begin : g_sbox
			aesrt_sbox u_sbox (.din(st_s1[g]), .fwd(sub_f[g]), .inv(sub_i[g]));
		end
	endgenerate

	aesrt_mix u_mix (.din(st_s1), .fwd(mix_f), .inv(mix_i));

	always_comb begin
		nxt = st_s1;
		unique case (act_s1)
			ACT_ADDKEY:   nxt = st_s1 ^ key_s1;
			ACT_SUB:      nxt = sub_f;
			ACT_INVSUB:   nxt = sub_i;
			ACT_SHIFT: begin
				for (int r = 0; r < 4; r++)
					for (int c = 0; c < 4; c++)
						nxt[c * 4 + r] = st_s1[((c + r) % 4) * 4 + r];
			end
			ACT_INVSHIFT: begin
				for (int r = 0; r < 4; r++)
					for (int c = 0; c < 4; c++)
						nxt[c * 4 + r] = st_s1[((c + 4 - r) % 4) * 4 + r];
			end
			ACT_MIX:      nxt = mix_f;
			ACT_INVMIX:   nxt = mix_i;
			ACT_PASS:     nxt = st_s1;
			default:      nxt = st_s1;
		endcase
	end

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			result_hi[63 - 8 * i -: 8] = res_s2[i];
			result_lo[63 - 8 * i -: 8] = res_s2[8 + i];
		end
	end

	assign out_valid = vld_s2;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && out_stall |=> vld_s2 && $stable(res_s2))
		else $error("result lost under stall");
	a_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && adv_s2 |=> vld_s2)
		else $error("stage 1 word dropped");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> vld_s1 && vld_s2 && out_stall)
		else $error("spurious input stall");

endmodule
